// ===== src/lpi_pkg.sv =====
package lpi_pkg;

  localparam int unsigned CW = 32;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned FIFO_DEPTH_DEF = 4;
  localparam int unsigned NC = 3;
  localparam int unsigned VW = CW + 1;
  localparam int unsigned NW = 2 * CW + 1;
  localparam int unsigned DNW = 2 * CW + 2;
  localparam int unsigned AW = 2 * CW;
  localparam int unsigned MW = CW;
  localparam int unsigned PW = AW + MW;
  localparam int unsigned QW = CW + 1;
  localparam int unsigned RW = DNW + QW;
  localparam int unsigned SW = CW + 3;

  typedef struct packed {
    logic [NC-1:0][CW-1:0] s;
    logic [NC-1:0][VW-1:0] v;
    logic [NW-1:0]         num;
    logic [DNW-1:0]        den;
  } item_t;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [QW-1:0] q;
    logic [CW-1:0] s;
    logic          negq;
    logic          sat;
  } lane_t;

  typedef struct packed {
    logic              hit;
    logic [DNW-1:0]    aden;
    lane_t [NC-1:0]    ln;
  } dstage_t;

endpackage

// ===== src/lpi_front.sv =====
module lpi_front #(
  parameter int unsigned FRAC_BITS = lpi_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [lpi_pkg::CW-1:0]     start_x_i,
  input  logic signed [lpi_pkg::CW-1:0]     start_y_i,
  input  logic signed [lpi_pkg::CW-1:0]     start_z_i,
  input  logic signed [lpi_pkg::CW-1:0]     end_x_i,
  input  logic signed [lpi_pkg::CW-1:0]     end_y_i,
  input  logic signed [lpi_pkg::CW-1:0]     end_z_i,
  input  logic signed [lpi_pkg::CW-1:0]     normal_x_i,
  input  logic signed [lpi_pkg::CW-1:0]     normal_y_i,
  input  logic signed [lpi_pkg::CW-1:0]     normal_z_i,
  input  logic signed [lpi_pkg::CW-1:0]     plane_offset_i,
  output logic                              item_valid_o,
  input  logic                              item_ready_i,
  output lpi_pkg::item_t                    item_o
);
  import lpi_pkg::*;

  logic adv;
  logic v1_q, v2_q, v3_q;

  logic signed [CW-1:0]      s1_q [NC];
  logic signed [VW-1:0]      d1v_q [NC];
  logic signed [CW-1:0]      n1_q [NC];
  logic signed [CW-1:0]      off1_q;

  logic signed [CW-1:0]      s2_q [NC];
  logic signed [VW-1:0]      d2v_q [NC];
  logic signed [AW-1:0]      pns_q [NC];
  logic signed [CW+VW-1:0]   pnv_q [NC];
  logic signed [CW-1:0]      off2_q;

  item_t item_d, item_q;

  assign adv          = !v3_q || item_ready_i;
  assign in_ready_o   = adv;
  assign item_valid_o = v3_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q[0]  <= start_x_i;
      s1_q[1]  <= start_y_i;
      s1_q[2]  <= start_z_i;
      d1v_q[0] <= VW'(end_x_i) - VW'(start_x_i);
      d1v_q[1] <= VW'(end_y_i) - VW'(start_y_i);
      d1v_q[2] <= VW'(end_z_i) - VW'(start_z_i);
      n1_q[0]  <= normal_x_i;
      n1_q[1]  <= normal_y_i;
      n1_q[2]  <= normal_z_i;
      off1_q   <= plane_offset_i;
      for (int c = 0; c < NC; c++) begin
        s2_q[c]  <= s1_q[c];
        d2v_q[c] <= d1v_q[c];
        pns_q[c] <= AW'(n1_q[c]) * AW'(s1_q[c]);
        pnv_q[c] <= (CW+VW)'(n1_q[c]) * (CW+VW)'(d1v_q[c]);
      end
      off2_q <= off1_q;
      item_q <= item_d;
    end
  end

  always_comb begin
    logic signed [NW-1:0]  num;
    logic signed [DNW-1:0] den;
    num = (NW'(off2_q) <<< FRAC_BITS) - NW'(pns_q[0]) - NW'(pns_q[1]) - NW'(pns_q[2]);
    den = DNW'(pnv_q[0]) + DNW'(pnv_q[1]) + DNW'(pnv_q[2]);
    for (int c = 0; c < NC; c++) begin
      item_d.s[c] = s2_q[c];
      item_d.v[c] = d2v_q[c];
    end
    item_d.num = num;
    item_d.den = den;
  end

endmodule

// ===== src/lpi_fifo.sv =====
module lpi_fifo #(
  parameter int unsigned DEPTH = lpi_pkg::FIFO_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  input  lpi_pkg::item_t wr_data_i,
  output logic           rd_valid_o,
  input  logic           rd_ready_i,
  output lpi_pkg::item_t rd_data_o
);
  import lpi_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  item_t mem_q [DEPTH];
  logic [PtrW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [PtrW:0]   cnt_q, cnt_d;
  logic push, pop;

  assign wr_ready_o = (cnt_q != (PtrW+1)'(DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rp_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push) wp_d = (wp_q == PtrW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
    if (pop)  rp_d = (rp_q == PtrW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
    if (push && !pop) cnt_d = cnt_q + 1'b1;
    else if (pop && !push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= wr_data_i;
  end

endmodule

// ===== src/lpi_back.sv =====
module lpi_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          item_valid_i,
  output logic                          item_ready_o,
  input  lpi_pkg::item_t                item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          hit_o,
  output logic signed [lpi_pkg::CW-1:0] hit_x_o,
  output logic signed [lpi_pkg::CW-1:0] hit_y_o,
  output logic signed [lpi_pkg::CW-1:0] hit_z_o,
  output logic                          overflow_o
);
  import lpi_pkg::*;

  logic adv;
  logic a_vld_q, b_vld_q, c_vld_q, out_vld_q;
  logic [QW:0] dv_q;

  // stage A: magnitudes and signs
  logic              a_hit_q;
  logic [DNW-1:0]    a_aden_q;
  logic [AW-1:0]     a_anum_q;
  logic [MW-1:0]     a_m_q [NC];
  logic              a_negq_q [NC];
  logic [CW-1:0]     a_s_q [NC];

  // stage B: partial products
  logic              b_hit_q;
  logic [DNW-1:0]    b_aden_q;
  logic [AW-1:0]     b_pl_q [NC];
  logic [AW-1:0]     b_ph_q [NC];
  logic              b_negq_q [NC];
  logic [CW-1:0]     b_s_q [NC];

  // stage C: dividend
  logic              c_hit_q;
  logic [DNW-1:0]    c_aden_q;
  logic [PW-1:0]     c_p_q [NC];
  logic              c_negq_q [NC];
  logic [CW-1:0]     c_s_q [NC];

  dstage_t st_q [QW+1];
  dstage_t st0_d;
  dstage_t nx_d [QW];

  logic              hit_q, ovf_q;
  logic [NC-1:0][CW-1:0] coord_q;
  logic [NC-1:0][CW-1:0] coord_d;
  logic              ovf_d;

  assign adv          = !out_vld_q || out_ready_i;
  assign item_ready_o = adv;
  assign out_valid_o  = out_vld_q;
  assign hit_o        = hit_q;
  assign hit_x_o      = coord_q[0];
  assign hit_y_o      = coord_q[1];
  assign hit_z_o      = coord_q[2];
  assign overflow_o   = ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      c_vld_q   <= 1'b0;
      dv_q      <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q   <= item_valid_i;
      b_vld_q   <= a_vld_q;
      c_vld_q   <= b_vld_q;
      dv_q      <= {dv_q[QW-1:0], c_vld_q};
      out_vld_q <= dv_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [NW-1:0]  num;
    logic signed [DNW-1:0] den;
    logic signed [VW-1:0]  vv;
    if (adv) begin
      num      = $signed(item_i.num);
      den      = $signed(item_i.den);
      a_hit_q  <= (den != '0);
      a_aden_q <= den[DNW-1] ? DNW'(-den) : DNW'(den);
      a_anum_q <= num[NW-1] ? AW'(-num) : AW'(num);
      for (int c = 0; c < NC; c++) begin
        vv          = $signed(item_i.v[c]);
        a_m_q[c]    <= vv[VW-1] ? MW'(-vv) : MW'(vv);
        a_negq_q[c] <= vv[VW-1] ^ num[NW-1] ^ den[DNW-1];
        a_s_q[c]    <= item_i.s[c];
      end
      b_hit_q  <= a_hit_q;
      b_aden_q <= a_aden_q;
      for (int c = 0; c < NC; c++) begin
        b_pl_q[c]   <= AW'(a_anum_q[CW-1:0]) * AW'(a_m_q[c]);
        b_ph_q[c]   <= AW'(a_anum_q[AW-1:CW]) * AW'(a_m_q[c]);
        b_negq_q[c] <= a_negq_q[c];
        b_s_q[c]    <= a_s_q[c];
      end
      c_hit_q  <= b_hit_q;
      c_aden_q <= b_aden_q;
      for (int c = 0; c < NC; c++) begin
        c_p_q[c]    <= {b_ph_q[c], {CW{1'b0}}} + PW'(b_pl_q[c]);
        c_negq_q[c] <= b_negq_q[c];
        c_s_q[c]    <= b_s_q[c];
      end
      st_q[0] <= st0_d;
      for (int k = 0; k < QW; k++) st_q[k+1] <= nx_d[k];
    end
  end

  always_comb begin
    st0_d.hit  = c_hit_q;
    st0_d.aden = c_aden_q;
    for (int c = 0; c < NC; c++) begin
      st0_d.ln[c].rem  = RW'(c_p_q[c]);
      st0_d.ln[c].q    = '0;
      st0_d.ln[c].s    = c_s_q[c];
      st0_d.ln[c].negq = c_negq_q[c];
      st0_d.ln[c].sat  = (RW'(c_p_q[c]) >= (RW'(c_aden_q) << QW));
    end
  end

  // one quotient bit per stage, MSB first
  always_comb begin
    logic [RW-1:0] t;
    for (int k = 0; k < QW; k++) begin
      t       = RW'(st_q[k].aden) << (QW - 1 - k);
      nx_d[k] = st_q[k];
      for (int c = 0; c < NC; c++) begin
        if (st_q[k].ln[c].rem >= t) begin
          nx_d[k].ln[c].rem           = st_q[k].ln[c].rem - t;
          nx_d[k].ln[c].q[QW - 1 - k] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    logic signed [SW-1:0] sq, qq, r;
    ovf_d   = 1'b0;
    coord_d = '0;
    for (int c = 0; c < NC; c++) begin
      sq = SW'($signed(st_q[QW].ln[c].s));
      qq = $signed(SW'(st_q[QW].ln[c].q));
      r  = st_q[QW].ln[c].negq ? sq - qq : sq + qq;
      if (st_q[QW].ln[c].sat) begin
        ovf_d = 1'b1;
        coord_d[c] = st_q[QW].ln[c].negq ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end else if (r > $signed(SW'({1'b0, {(CW-1){1'b1}}}))) begin
        ovf_d = 1'b1;
        coord_d[c] = {1'b0, {(CW-1){1'b1}}};
      end else if (r < -$signed(SW'({1'b1, {(CW-1){1'b0}}}))) begin
        ovf_d = 1'b1;
        coord_d[c] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        coord_d[c] = r[CW-1:0];
      end
    end
    if (!st_q[QW].hit) begin
      ovf_d   = 1'b0;
      coord_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit_q   <= st_q[QW].hit;
      ovf_q   <= ovf_d;
      coord_q <= coord_d;
    end
  end

`ifndef ASSERT_OFF
  a_nohit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !hit_q |-> coord_q == '0 && !ovf_q)
    else $error("no-hit transaction with nonzero result");
  a_ovf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && ovf_q |->
      coord_q[0] == {1'b0, {(CW-1){1'b1}}} || coord_q[0] == {1'b1, {(CW-1){1'b0}}} ||
      coord_q[1] == {1'b0, {(CW-1){1'b1}}} || coord_q[1] == {1'b1, {(CW-1){1'b0}}} ||
      coord_q[2] == {1'b0, {(CW-1){1'b1}}} || coord_q[2] == {1'b1, {(CW-1){1'b0}}})
    else $error("overflow without saturated coordinate");
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(dv_q) && $stable(c_vld_q))
    else $error("pipeline moved during stall");
`endif

endmodule

// ===== src/line_plane_intersection.sv =====
// Line/plane intersection, signed fixed point, fully pipelined.
// Pipeline registers from input to result valid: 3 front, 1 queue, 3 setup, 34 divider,
// 1 output; the first loads on accept. Throughput: one transaction per cycle unless
// out_ready_i stalls the output; every stage, the divider included, is pipelined.
// Reset: asynchronous active low; clears all valid bits and queue pointers.
module line_plane_intersection #(
  parameter int unsigned FRAC_BITS  = lpi_pkg::FRAC_BITS_DEF,
  parameter int unsigned FIFO_DEPTH = lpi_pkg::FIFO_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [lpi_pkg::CW-1:0] start_x_i,
  input  logic signed [lpi_pkg::CW-1:0] start_y_i,
  input  logic signed [lpi_pkg::CW-1:0] start_z_i,
  input  logic signed [lpi_pkg::CW-1:0] end_x_i,
  input  logic signed [lpi_pkg::CW-1:0] end_y_i,
  input  logic signed [lpi_pkg::CW-1:0] end_z_i,
  input  logic signed [lpi_pkg::CW-1:0] normal_x_i,
  input  logic signed [lpi_pkg::CW-1:0] normal_y_i,
  input  logic signed [lpi_pkg::CW-1:0] normal_z_i,
  input  logic signed [lpi_pkg::CW-1:0] plane_offset_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          hit_o,
  output logic signed [lpi_pkg::CW-1:0] hit_x_o,
  output logic signed [lpi_pkg::CW-1:0] hit_y_o,
  output logic signed [lpi_pkg::CW-1:0] hit_z_o,
  output logic                          overflow_o
);
  import lpi_pkg::*;

  logic  f_vld, f_rdy, b_vld, b_rdy;
  item_t f_item, b_item;

  lpi_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .start_x_i, .start_y_i, .start_z_i, .end_x_i, .end_y_i, .end_z_i,
    .normal_x_i, .normal_y_i, .normal_z_i, .plane_offset_i,
    .item_valid_o(f_vld), .item_ready_i(f_rdy), .item_o(f_item)
  );

  lpi_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(f_vld), .wr_ready_o(f_rdy), .wr_data_i(f_item),
    .rd_valid_o(b_vld), .rd_ready_i(b_rdy), .rd_data_o(b_item)
  );

  lpi_back u_back (
    .clk_i, .rst_ni,
    .item_valid_i(b_vld), .item_ready_o(b_rdy), .item_i(b_item),
    .out_valid_o, .out_ready_i,
    .hit_o, .hit_x_o, .hit_y_o, .hit_z_o, .overflow_o
  );

endmodule

// ===== bench/line_plane_intersection_test.sv =====
`timescale 1ns / 1ps

module line_plane_intersection_test;
  import lpi_pkg::*;

  localparam int unsigned FRAC = 16;
  localparam int unsigned LATENCY = 41;

  typedef struct {
    logic signed [CW-1:0] p0[3];
    logic signed [CW-1:0] p1[3];
    logic signed [CW-1:0] nrm[3];
    logic signed [CW-1:0] offs;
  } query_t;

  typedef struct {
    logic                 hit;
    logic signed [CW-1:0] pt[3];
    logic                 ovf;
  } point_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [CW-1:0] start_x_i = '0, start_y_i = '0, start_z_i = '0;
  logic signed [CW-1:0] end_x_i = '0, end_y_i = '0, end_z_i = '0;
  logic signed [CW-1:0] normal_x_i = '0, normal_y_i = '0, normal_z_i = '0;
  logic signed [CW-1:0] plane_offset_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic hit_o;
  logic signed [CW-1:0] hit_x_o, hit_y_o, hit_z_o;
  logic overflow_o;

  query_t pending_queries[$];
  point_t expected_points[$];
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  int     errors = 0;

  line_plane_intersection uut (.*);

  always #10 clk_i = ~clk_i;

  function automatic point_t intersect_point(query_t q);
    logic signed [127:0] s[3], v[3], n[3];
    logic signed [127:0] num, den, r;
    logic [127:0] anum, aden, av, quo;
    logic negq;
    point_t res;
    num = 128'(signed'(q.offs)) <<< FRAC;
    den = '0;
    for (int c = 0; c < 3; c++) begin
      s[c] = q.p0[c];
      v[c] = 128'(signed'(q.p1[c])) - s[c];
      n[c] = q.nrm[c];
      den = den + n[c] * v[c];
      num = num - n[c] * s[c];
    end
    res.hit = 1'b0;
    res.ovf = 1'b0;
    for (int c = 0; c < 3; c++) res.pt[c] = '0;
    if (den == 0) return res;
    res.hit = 1'b1;
    anum = (num < 0) ? -num : num;
    aden = (den < 0) ? -den : den;
    for (int c = 0; c < 3; c++) begin
      av = (v[c] < 0) ? -v[c] : v[c];
      quo = (anum * av) / aden;
      negq = (v[c] < 0) ^ (num < 0) ^ (den < 0);
      if (quo > 128'h1_0000_0000) begin
        res.ovf = 1'b1;
        res.pt[c] = negq ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
        r = negq ? s[c] - $signed(quo) : s[c] + $signed(quo);
        if (r > 128'sd2147483647) begin
          r = 128'sd2147483647;
          res.ovf = 1'b1;
        end else if (r < -128'sd2147483648) begin
          r = -128'sd2147483648;
          res.ovf = 1'b1;
        end
        res.pt[c] = r[CW-1:0];
      end
    end
    return res;
  endfunction

  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed(32'($urandom_range(0, 32'h0100_0000))) - 32'sh0080_0000;
      2: return $signed(32'($urandom_range(0, 32'h0010_0000))) - 32'sh0008_0000;
      default: return $signed(32'($urandom_range(0, 20))) - 10;
    endcase
  endfunction

  function automatic query_t rand_query();
    query_t q;
    for (int c = 0; c < 3; c++) begin
      q.p0[c] = rand_coord();
      q.p1[c] = ($urandom_range(0, 9) == 0) ? q.p0[c] : rand_coord();
      q.nrm[c] = ($urandom_range(0, 7) == 0) ? '0 : rand_coord();
    end
    q.offs = rand_coord();
    return q;
  endfunction

  function automatic query_t fill_query(logic signed [CW-1:0] a, logic signed [CW-1:0] b,
                                        logic signed [CW-1:0] nv, logic signed [CW-1:0] d);
    query_t q;
    for (int c = 0; c < 3; c++) begin
      q.p0[c] = a;
      q.p1[c] = b;
      q.nrm[c] = nv;
    end
    q.offs = d;
    return q;
  endfunction

  // driver
  always @(posedge clk_i) begin
    query_t q;
    logic   next_valid;
    next_valid = in_valid_i;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        q.p0 = '{start_x_i, start_y_i, start_z_i};
        q.p1 = '{end_x_i, end_y_i, end_z_i};
        q.nrm = '{normal_x_i, normal_y_i, normal_z_i};
        q.offs = plane_offset_i;
        expected_points.push_back(intersect_point(q));
        next_valid = 1'b0;
      end
      if (!next_valid && pending_queries.size() > 0 &&
          $urandom_range(1, 100) > send_idle_pct) begin
        q = pending_queries.pop_front();
        start_x_i <= q.p0[0];
        start_y_i <= q.p0[1];
        start_z_i <= q.p0[2];
        end_x_i <= q.p1[0];
        end_y_i <= q.p1[1];
        end_z_i <= q.p1[2];
        normal_x_i <= q.nrm[0];
        normal_y_i <= q.nrm[1];
        normal_z_i <= q.nrm[2];
        plane_offset_i <= q.offs;
        next_valid = 1'b1;
      end
      in_valid_i <= next_valid;
      out_ready_i <= ($urandom_range(1, 100) > recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    point_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_points.size() == 0) begin
        $error("unexpected transaction");
        errors++;
      end else begin
        e = expected_points.pop_front();
        if (hit_o !== e.hit) begin
          $error("hit: expected %0d, actual %0d", e.hit, hit_o);
          errors++;
        end
        if (hit_x_o !== e.pt[0]) begin
          $error("hit_x: expected %0d, actual %0d", e.pt[0], hit_x_o);
          errors++;
        end
        if (hit_y_o !== e.pt[1]) begin
          $error("hit_y: expected %0d, actual %0d", e.pt[1], hit_y_o);
          errors++;
        end
        if (hit_z_o !== e.pt[2]) begin
          $error("hit_z: expected %0d, actual %0d", e.pt[2], hit_z_o);
          errors++;
        end
        if (overflow_o !== e.ovf) begin
          $error("overflow: expected %0d, actual %0d", e.ovf, overflow_o);
          errors++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int sends[4];
    int stalls[4];
    query_t q;
    sends = '{0, 81, 0, 10};
    stalls = '{0, 0, 81, 10};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed
    pending_queries.push_back(fill_query('0, '0, '0, '0));
    pending_queries.push_back(fill_query(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                                         32'sh8000_0000));
    pending_queries.push_back(fill_query(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                                         32'sh7FFF_FFFF));
    pending_queries.push_back(fill_query(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000,
                                         '0));
    pending_queries.push_back(fill_query(32'sh0001_0000, 32'sh0002_0000, '0, '0));
    pending_queries.push_back(fill_query(-32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000,
                                         '0));
    pending_queries.push_back(fill_query(32'sh0000_0000, 32'sh0000_0001, 32'sh0000_0001,
                                         32'sh7FFF_FFFF));
    pending_queries.push_back(fill_query(32'sh0000_0000, -32'sh0000_0001, 32'sh0000_0001,
                                         32'sh7FFF_FFFF));
    pending_queries.push_back(fill_query(32'shFFFF_FFFF, 32'sh0000_0000, 32'sh7FFF_FFFF,
                                         32'sh0000_0001));
    q = fill_query(32'sh0001_0000, 32'sh0003_0000, '0, 32'sh0002_0000);
    q.nrm[0] = 32'sh0001_0000;
    q.p1[1] = 32'sh0001_0000;
    pending_queries.push_back(q);
    q = fill_query('0, 32'sh0001_0000, '0, 32'sh0001_0000);
    q.nrm[2] = 32'sh0001_0000;
    q.p1[2] = '0;
    pending_queries.push_back(q);
    q = fill_query(32'sh7FFF_0000, 32'sh7FFF_FFFF, 32'sh0000_0001, 32'sh8000_0000);
    pending_queries.push_back(q);
    while (pending_queries.size() != 0 || expected_points.size() != 0 || in_valid_i)
      @(negedge clk_i);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = sends[ph];
      recv_stall_pct = stalls[ph];
      for (int i = 0; i < 185; i++) pending_queries.push_back(rand_query());
      while (pending_queries.size() != 0 || expected_points.size() != 0 || in_valid_i)
        @(negedge clk_i);
      repeat (3) @(posedge clk_i);
    end

    repeat (LATENCY + 20) @(posedge clk_i);
    if (errors == 0 && expected_points.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/lpi_pkg.sv
src/lpi_front.sv
src/lpi_fifo.sv
src/lpi_back.sv
src/line_plane_intersection.sv
bench/line_plane_intersection_test.sv
